>>> sv/ltp_pkg.sv
// Shared types, constants and the LFSR tap table for the tile permutation block.
`timescale 1ns / 1ps
package ltp_pkg;

  localparam int INDEX_BITS     = 24;
  localparam int ROW_LEN_BITS   = 12;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 2;
  localparam int SEED_BITS      = 64;

  localparam logic [31:0] GOLDEN_MUL = 32'd2654435761;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TILE_COUNT = 2'd1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic                  last;
  } tile_t;

  function automatic logic [31:0] tap_word(input logic [4:0] width);
    logic [31:0] taps;
    case (width)
      5'd0:    taps = 32'h0;
      5'd1:    taps = 32'h1;
      5'd2:    taps = 32'h3;
      5'd3:    taps = 32'h6;
      5'd4:    taps = 32'hc;
      5'd5:    taps = 32'h1e;
      5'd6:    taps = 32'h36;
      5'd7:    taps = 32'h78;
      5'd8:    taps = 32'hb8;
      5'd9:    taps = 32'h1b0;
      5'd10:   taps = 32'h360;
      5'd11:   taps = 32'h740;
      5'd12:   taps = 32'hca0;
      5'd13:   taps = 32'h1b00;
      5'd14:   taps = 32'h3500;
      5'd15:   taps = 32'h7400;
      5'd16:   taps = 32'hb400;
      5'd17:   taps = 32'h1e000;
      5'd18:   taps = 32'h39000;
      5'd19:   taps = 32'h72000;
      5'd20:   taps = 32'hca000;
      5'd21:   taps = 32'h1c8000;
      5'd22:   taps = 32'h270000;
      5'd23:   taps = 32'h6a0000;
      5'd24:   taps = 32'hd80000;
      5'd25:   taps = 32'h1e00000;
      5'd26:   taps = 32'h3880000;
      5'd27:   taps = 32'h7200000;
      5'd28:   taps = 32'hca00000;
      5'd29:   taps = 32'h1d000000;
      5'd30:   taps = 32'h32800000;
      5'd31:   taps = 32'h78000000;
      default: taps = 32'h0;
    endcase
    return taps;
  endfunction

endpackage

>>> sv/ltp_front.sv
// Request front end: run setup, LFSR candidate search and tile hand-off to the queue.
`timescale 1ns / 1ps
module ltp_front #(
  parameter int MAX_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ltp_pkg::INDEX_BITS-1:0]  tile_count,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [ltp_pkg::SEED_BITS-1:0]   seed,
  output logic                            push,
  output ltp_pkg::tile_t                  push_entry,
  input  logic                            full
);
  import ltp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MIX, S_SEARCH, S_PUSH} state_t;

  state_t                 state;
  logic                   run_active;
  logic                   first_pending;
  logic [31:0]            seed_hi;
  logic [MAX_BITS-1:0]    shift_register;
  logic [MAX_BITS-1:0]    stream_mask;
  logic [MAX_BITS-1:0]    tap_mask;
  logic [MAX_BITS-1:0]    width_mask;
  logic [MAX_BITS-1:0]    step_count;
  logic [INDEX_BITS-1:0]  tiles_left;
  logic [INDEX_BITS-1:0]  candidate;

  logic [4:0]             width_raw;
  logic [4:0]             width;
  logic [MAX_BITS-1:0]    new_width_mask;
  logic [MAX_BITS-1:0]    stepped;
  logic [MAX_BITS-1:0]    trial;
  logic                   hit;
  logic [31:0]            product;
  logic [INDEX_BITS-1:0]  tiles_left_next;

  always_comb begin
    width_raw = 5'd0;
    for (int i = 0; i < INDEX_BITS; i++) begin
      if (tile_count[i]) begin
        width_raw = 5'(i + 1);
      end
    end
    width = width_raw;
    if (int'(width_raw) > MAX_BITS) begin
      width = 5'(MAX_BITS);
    end
  end

  assign new_width_mask  = MAX_BITS'((33'd1 << width) - 33'd1);
  assign stepped         = ((shift_register >> 1) ^ (shift_register[0] ? tap_mask : '0))
                           & width_mask;
  assign trial           = first_pending ? stream_mask : (stepped ^ stream_mask);
  assign hit             = 32'(trial) < 32'(tile_count);
  assign product         = seed_hi * GOLDEN_MUL;
  assign tiles_left_next = tiles_left - 1'b1;

  assign in_ready         = (state == S_IDLE);
  assign push             = (state == S_PUSH) && !full;
  assign push_entry.index = candidate;
  assign push_entry.last  = (tiles_left_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      run_active    <= 1'b0;
      first_pending <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (command == CMD_START) begin
              seed_hi        <= seed[63:32];
              shift_register <= MAX_BITS'(seed[31:0] | 32'd1) & new_width_mask;
              width_mask     <= new_width_mask;
              tap_mask       <= MAX_BITS'(tap_word(width));
              tiles_left     <= tile_count;
              first_pending  <= 1'b1;
              run_active     <= (tile_count != '0);
              state          <= S_MIX;
            end else if (run_active) begin
              step_count <= '0;
              state      <= S_SEARCH;
            end
          end
        end
        S_MIX: begin
          stream_mask <= MAX_BITS'(product) & width_mask;
          state       <= S_IDLE;
        end
        S_SEARCH: begin
          if (first_pending) begin
            first_pending <= 1'b0;
          end else begin
            shift_register <= stepped;
            step_count     <= step_count + 1'b1;
          end
          if (hit) begin
            candidate <= INDEX_BITS'(trial);
            state     <= S_PUSH;
          end else if (!first_pending && step_count == width_mask) begin
            run_active <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_PUSH: begin
          if (!full) begin
            tiles_left <= tiles_left_next;
            if (tiles_left_next == '0) begin
              run_active <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ltp_queue.sv
// Small first-in first-out queue between the search front end and the divider.
`timescale 1ns / 1ps
module ltp_queue #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] storage [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full     = (fill == CW'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = storage[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        storage[wr_ptr] <= push_data;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> sv/ltp_divider.sv
// Back end: restoring divider that splits a tile index into column and row, with output register.
`timescale 1ns / 1ps
module ltp_divider #(
  parameter int COLUMN_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ltp_pkg::ROW_LEN_BITS-1:0] row_length,
  input  logic                             entry_valid,
  input  ltp_pkg::tile_t                   entry,
  output logic                             take,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [COLUMN_BITS-1:0]           column,
  output logic [ltp_pkg::INDEX_BITS-1:0]   row,
  output logic                             last
);
  import ltp_pkg::*;

  localparam int BW = $clog2(INDEX_BITS);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  state_t                  state;
  logic [INDEX_BITS-1:0]   quotient;
  logic [ROW_LEN_BITS-1:0] remainder;
  logic [BW-1:0]           bit_count;
  logic                    last_flag;

  logic [ROW_LEN_BITS:0]   shifted;
  logic [ROW_LEN_BITS:0]   diff;

  assign shifted = {remainder, quotient[INDEX_BITS-1]};
  assign diff    = shifted - {1'b0, row_length};
  assign take    = (state == S_IDLE) && entry_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (entry_valid) begin
            quotient  <= entry.index;
            remainder <= '0;
            last_flag <= entry.last;
            bit_count <= '0;
            state     <= (row_length == '0) ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (!diff[ROW_LEN_BITS]) begin
            remainder <= diff[ROW_LEN_BITS-1:0];
          end else begin
            remainder <= shifted[ROW_LEN_BITS-1:0];
          end
          quotient  <= {quotient[INDEX_BITS-2:0], ~diff[ROW_LEN_BITS]};
          bit_count <= bit_count + 1'b1;
          if (bit_count == BW'(INDEX_BITS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            column    <= COLUMN_BITS'(remainder);
            row       <= quotient;
            last      <= last_flag;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/lfsr_tile_permutation.sv
// Top level of the pseudo-random tile permutation block: configuration and the three parts.
//
// Requests arrive on in_valid/in_ready with a command and a 64-bit seed. A start request
// (command 0) sets up a run from the seed and the current tile_count and gives no result.
// A next request (command 1) searches the LFSR for the next tile index below tile_count
// (usually one or two steps), places it in a two-entry queue, and the divider splits it
// into column and row by restoring division. A next request with no run active gives no
// result. Results leave on out_valid/out_ready with column, row and last, which marks the
// final tile of the run. The divider takes a new tile only after it has handed the last
// one to the output register. The front end keeps taking requests while the divider works,
// until the queue fills; a stalled receiver holds the output register and, behind it, the
// queue and the front end.
// Configuration is written through write_enable, write_index and write_data while no
// request is in flight; the user keeps to this, as the block itself does not enforce it.
// Reset clears any run and returns row_length to 80 and tile_count to 2000.
`timescale 1ns / 1ps
module lfsr_tile_permutation #(
  parameter int MAX_BITS    = 24,
  parameter int COLUMN_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [ltp_pkg::CFG_INDEX_BITS-1:0] write_index,
  input  logic [ltp_pkg::CFG_DATA_BITS-1:0]  write_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic [ltp_pkg::SEED_BITS-1:0]      seed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [COLUMN_BITS-1:0]             column,
  output logic [ltp_pkg::INDEX_BITS-1:0]     row,
  output logic                               last
);
  import ltp_pkg::*;

  logic [ROW_LEN_BITS-1:0] row_length;
  logic [INDEX_BITS-1:0]   tile_count;

  logic  push;
  tile_t push_entry;
  logic  full;
  logic  take;
  tile_t pop_entry;
  logic  empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LEN_BITS'(80);
      tile_count <= INDEX_BITS'(2000);
    end else if (write_enable) begin
      case (write_index)
        REG_ROW_LENGTH: row_length <= write_data[ROW_LEN_BITS-1:0];
        REG_TILE_COUNT: tile_count <= write_data[INDEX_BITS-1:0];
        default: ;
      endcase
    end
  end

  ltp_front #(
    .MAX_BITS(MAX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .tile_count (tile_count),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .seed       (seed),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  ltp_queue #(
    .WIDTH($bits(tile_t)),
    .DEPTH(2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (full),
    .pop       (take),
    .pop_data  (pop_entry),
    .empty     (empty)
  );

  ltp_divider #(
    .COLUMN_BITS(COLUMN_BITS)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .row_length  (row_length),
    .entry_valid (!empty),
    .entry       (pop_entry),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .column      (column),
    .row         (row),
    .last        (last)
  );

endmodule

>>> tb/tb_lfsr_tile_permutation.sv
// Self-checking testbench that predicts and checks every tile of the pseudo-random permutation.
`timescale 1ns / 1ps
module tb_lfsr_tile_permutation;
  import ltp_pkg::*;

  localparam int COL_W           = 12;
  localparam int SETTLE_CYCLES   = 64;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 150;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic        cmd;
    logic [63:0] seed;
  } request_t;

  typedef struct {
    logic [COL_W-1:0]      column;
    logic [INDEX_BITS-1:0] row;
    logic                  last;
  } tile_result_t;

  logic                      clk;
  logic                      rst;
  logic                      write_enable;
  logic [CFG_INDEX_BITS-1:0] write_index;
  logic [CFG_DATA_BITS-1:0]  write_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      command;
  logic [SEED_BITS-1:0]      seed;
  logic                      out_valid;
  logic                      out_ready;
  logic [COL_W-1:0]          column;
  logic [INDEX_BITS-1:0]     row;
  logic                      last;

  request_t     pending_requests[$];
  tile_result_t tiles_due[$];
  bit           request_taken;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           error_count;
  int           requests_sent;
  int           starts_sent;
  int           tiles_checked;
  int           run_ends_seen;
  int           settings_used;

  // Predicted configuration and run state of the block.
  logic [11:0] row_len_q;
  logic [23:0] tile_count_q;
  logic [23:0] lfsr_q;
  logic [23:0] mask_q;
  logic [23:0] left_q;
  logic [23:0] taps_q;
  logic [23:0] width_mask_q;
  logic        active_q;
  logic        first_q;

  lfsr_tile_permutation u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned width_of(input logic [23:0] tiles);
    int unsigned n;
    n = 0;
    while (tiles != 0) begin
      n++;
      tiles = tiles >> 1;
    end
    return n;
  endfunction

  function automatic logic [23:0] tap_for_width(input int unsigned w);
    logic [23:0] taps;
    case (w)
      1:       taps = 24'h1;
      2:       taps = 24'h3;
      3:       taps = 24'h6;
      4:       taps = 24'hc;
      5:       taps = 24'h1e;
      6:       taps = 24'h36;
      7:       taps = 24'h78;
      8:       taps = 24'hb8;
      9:       taps = 24'h1b0;
      10:      taps = 24'h360;
      11:      taps = 24'h740;
      12:      taps = 24'hca0;
      13:      taps = 24'h1b00;
      14:      taps = 24'h3500;
      15:      taps = 24'h7400;
      16:      taps = 24'hb400;
      17:      taps = 24'h1e000;
      18:      taps = 24'h39000;
      19:      taps = 24'h72000;
      20:      taps = 24'hca000;
      21:      taps = 24'h1c8000;
      22:      taps = 24'h270000;
      23:      taps = 24'h6a0000;
      24:      taps = 24'hd80000;
      default: taps = 24'h0;
    endcase
    return taps;
  endfunction

  task automatic start_run(input logic [63:0] s);
    int unsigned w;
    logic [31:0] hashed;
    logic [31:0] wm;
    w = width_of(tile_count_q);
    if (w > 24) w = 24;
    wm = (32'd1 << w) - 32'd1;
    width_mask_q = wm[23:0];
    taps_q = tap_for_width(w);
    hashed = s[63:32] * GOLDEN_MUL;
    mask_q = hashed[23:0] & width_mask_q;
    lfsr_q = (s[23:0] | 24'd1) & width_mask_q;
    left_q = tile_count_q;
    first_q = 1'b1;
    active_q = tile_count_q != 0;
  endtask

  function automatic bit next_tile(output tile_result_t res);
    logic [23:0] cand;
    logic [23:0] rem;
    bit found;
    int unsigned steps;
    int unsigned limit;
    found = 1'b0;
    cand = '0;
    if (!active_q) return 1'b0;
    if (first_q) begin
      first_q = 1'b0;
      cand = mask_q;
      found = cand < tile_count_q;
    end
    limit = width_mask_q + 1;
    for (steps = 0; !found && steps < limit; steps++) begin
      lfsr_q = ((lfsr_q >> 1) ^ (lfsr_q[0] ? taps_q : 24'd0)) & width_mask_q;
      cand = lfsr_q ^ mask_q;
      found = cand < tile_count_q;
    end
    if (!found) begin
      active_q = 1'b0;
      return 1'b0;
    end
    if (row_len_q == 0) begin
      res.column = '0;
      res.row = cand;
    end else begin
      rem = cand % row_len_q;
      res.column = rem[COL_W-1:0];
      res.row = cand / row_len_q;
    end
    left_q = left_q - 24'd1;
    if (left_q == 0) active_q = 1'b0;
    res.last = left_q == 0;
    return 1'b1;
  endfunction

  task automatic take_request(input logic cmd, input logic [63:0] s);
    tile_result_t res;
    requests_sent++;
    if (cmd == CMD_START) begin
      starts_sent++;
      start_run(s);
    end else if (next_tile(res)) begin
      tiles_due.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_request(input logic cmd, input logic [63:0] s);
    request_t r;
    r.cmd = cmd;
    r.seed = s;
    pending_requests.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= value;
    @(negedge clk);
    write_enable <= 1'b0;
    if (idx == REG_ROW_LENGTH) row_len_q = value[11:0];
    else if (idx == REG_TILE_COUNT) tile_count_q = value;
  endtask

  task automatic configure(input logic [23:0] row_data, input logic [23:0] tiles);
    write_reg(REG_ROW_LENGTH, row_data);
    write_reg(REG_TILE_COUNT, tiles);
    settings_used++;
  endtask

  // Waits until every request is taken and every predicted tile has come back.
  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || tiles_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    request_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !request_taken) begin
      // The request stays on the port until it is taken.
    end else if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      item = pending_requests.pop_front();
      command <= item.cmd;
      seed <= item.seed;
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
    request_taken = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    tile_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        request_taken = 1'b1;
        take_request(command, seed);
      end
      if (out_valid && out_ready) begin
        if (tiles_due.size() == 0) begin
          report_mismatch($sformatf("unexpected tile column %0d row %0d last %0d",
                                    column, row, last));
        end else begin
          want = tiles_due.pop_front();
          tiles_checked++;
          if (want.last) run_ends_seen++;
          if (column !== want.column)
            report_mismatch($sformatf("column %0d, expected %0d", column, want.column));
          if (row !== want.row)
            report_mismatch($sformatf("row %0d, expected %0d", row, want.row));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d requests queued and %0d tiles outstanding.",
             pending_requests.size(), tiles_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [23:0] tiles_pick;
    logic [23:0] row_pick;
    int          run_len;
    int          queued;
    int          pick;
    rst = 1'b1;
    write_enable = 1'b0;
    write_index = '0;
    write_data = '0;
    in_valid = 1'b0;
    command = CMD_START;
    seed = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    requests_sent = 0;
    starts_sent = 0;
    tiles_checked = 0;
    run_ends_seen = 0;
    settings_used = 1;
    row_len_q = 12'd80;
    tile_count_q = 24'd2000;
    lfsr_q = '0;
    mask_q = '0;
    left_q = '0;
    taps_q = '0;
    width_mask_q = '0;
    active_q = 1'b0;
    first_q = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: a next request with no run, then runs from the all-zero and all-one seeds.
    queue_request(CMD_NEXT, rand64());
    queue_request(CMD_START, 64'd0);
    queue_request(CMD_NEXT, rand64());
    queue_request(CMD_NEXT, rand64());
    queue_request(CMD_START, '1);
    queue_request(CMD_NEXT, rand64());
    drain();

    // Widest grid and longest rows; the upper data bits do not reach the row length.
    configure(24'hFFFFFF, 24'hFFFFFF);
    queue_request(CMD_START, {32'hFFFF_FFFF, 32'h0});
    queue_request(CMD_NEXT, '0);
    queue_request(CMD_NEXT, '1);
    drain();

    // A zero row length puts the whole index in the row; the full run ends with last.
    configure(24'hABC000, 24'd3);
    queue_request(CMD_START, rand64());
    repeat (4) queue_request(CMD_NEXT, rand64());
    drain();

    // Shrinking the tile count under an active run makes the search run dry.
    configure(24'd1, 24'd3);
    queue_request(CMD_START, rand64());
    queue_request(CMD_NEXT, rand64());
    drain();
    write_reg(REG_TILE_COUNT, 24'd1);
    repeat (3) queue_request(CMD_NEXT, rand64());
    drain();

    // An empty grid never starts a run, and writes past the register list change nothing.
    write_reg(REG_TILE_COUNT, 24'd0);
    write_reg(REG_SPARE_A, 24'h5A5A5A);
    write_reg(REG_SPARE_B, 24'hA5A5A5);
    queue_request(CMD_START, rand64());
    queue_request(CMD_NEXT, rand64());
    drain();

    configure(24'd4095, 24'd1);
    queue_request(CMD_START, rand64());
    queue_request(CMD_NEXT, rand64());
    queue_request(CMD_NEXT, rand64());
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct = 19;
          recv_stall_pct = 19;
        end
      endcase
      case (phase)
        0: begin
          row_pick = 24'd4095;
          tiles_pick = 24'hFFFFFF;
        end
        1: begin
          row_pick = 24'd1;
          tiles_pick = 24'd1;
        end
        2: begin
          row_pick = {12'($urandom_range(0, 4095)), 12'd0};
          tiles_pick = 24'($urandom_range(1, 120));
        end
        default: begin
          row_pick = ($urandom_range(0, 2) == 0) ? 24'($urandom_range(1, 4095))
                                                 : 24'($urandom_range(1, 20));
          row_pick[23:12] = 12'($urandom_range(0, 4095));
          tiles_pick = ($urandom_range(0, 4) == 0) ? 24'($urandom_range(1, 24'hFFFFFF))
                                                   : 24'($urandom_range(1, 120));
        end
      endcase
      configure(row_pick, tiles_pick);

      // Every phase opens with a start so that no run from the old settings is continued.
      queue_request(CMD_START, rand64());
      queued = 1;
      while (queued < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          queue_request(CMD_NEXT, rand64());
          queued++;
        end else if (pick < 10) begin
          queue_request(CMD_START, rand64());
          queued++;
        end else begin
          run_len = (tiles_pick <= 120) ? tiles_pick + $urandom_range(0, 2)
                                        : $urandom_range(1, 40);
          if ($urandom_range(0, 7) == 0) run_len = $urandom_range(1, run_len);
          queue_request(CMD_START, rand64());
          repeat (run_len) queue_request(CMD_NEXT, rand64());
          queued += run_len + 1;
        end
      end
      drain();
    end

    $display("Covered %0d requests (%0d starts) under %0d register settings and four idle mixes.",
             requests_sent, starts_sent, settings_used);
    $display("Checked %0d tiles, %0d of them closing a run; %0d mismatches.",
             tiles_checked, run_ends_seen, error_count);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
sv/ltp_pkg.sv
sv/ltp_front.sv
sv/ltp_queue.sv
sv/ltp_divider.sv
sv/lfsr_tile_permutation.sv
tb/tb_lfsr_tile_permutation.sv
